>>> design/assert_macros.svh
// Assertion macros used by the deframer parser (wsdf_parser).
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("deframer assertion failed");
`define ASSERT_CLK(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("deframer assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif

`endif

>>> design/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies.
`timescale 1ns / 1ps

package wsdf_pkg;

	localparam int LEN_W = 64;
	localparam int OUT_LEN_W = 64;
	localparam int MSG_W = 64;

	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES = 4'd4;

	typedef enum logic [5:0] {
		PH_FIRST   = 6'b000001,
		PH_SECOND  = 6'b000010,
		PH_EXT16   = 6'b000100,
		PH_EXT64   = 6'b001000,
		PH_KEY     = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	typedef struct packed {
		logic                 is_header;
		logic                 fin;
		logic [3:0]           opcode;
		logic                 masked;
		logic [OUT_LEN_W-1:0] payload_length;
		logic [7:0]           payload_byte;
		logic                 last_of_frame;
		logic                 last_of_message;
		logic [MSG_W-1:0]     message_length;
	} rec_t;

endpackage

>>> design/websocket_frame_deframer_top.sv
// Channel      Valid      Stall      Payload
// input        in_valid   in_stall   rx_byte
// output       out_valid  out_stall  is_header .. message_length
// One byte per cycle while in_stall is low; an input register feeds the parser and
// a result register holds each record, which out_valid then presents.
// Header bytes other than the last one produce no output transfer.
// in_stall rises only while a byte waits in the input register and the result
// register is full and stalled. Reset clears the parser to wait for a frame start.
// Top level of the deframer; depends on wsdf_pkg and wsdf_parser.
`timescale 1ns / 1ps

module websocket_frame_deframer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            is_header,
	output logic                            fin,
	output logic [3:0]                      opcode,
	output logic                            masked,
	output logic [wsdf_pkg::OUT_LEN_W-1:0]  payload_length,
	output logic [7:0]                      payload_byte,
	output logic                            last_of_frame,
	output logic                            last_of_message,
	output logic [wsdf_pkg::MSG_W-1:0]      message_length
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic valid_s2;
	wsdf_pkg::rec_t rec_s2;
	wsdf_pkg::rec_t rec;
	logic rec_valid;
	logic advance, step;

	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	wsdf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && rec_valid) begin
			rec_s2 <= rec;
		end
	end

	assign out_valid       = valid_s2;
	assign is_header       = rec_s2.is_header;
	assign fin             = rec_s2.fin;
	assign opcode          = rec_s2.opcode;
	assign masked          = rec_s2.masked;
	assign payload_length  = rec_s2.payload_length;
	assign payload_byte    = rec_s2.payload_byte;
	assign last_of_frame   = rec_s2.last_of_frame;
	assign last_of_message = rec_s2.last_of_message;
	assign message_length  = rec_s2.message_length;

endmodule

>>> design/wsdf_parser.sv
// Frame header parser state and per-byte update logic.
// Depends on wsdf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsdf_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output logic              rec_valid,
	output wsdf_pkg::rec_t    rec
);

	wsdf_pkg::phase_t phase_q, phase_d;
	logic [3:0] fbc_q, fbc_d;
	logic fin_q, fin_d;
	logic [3:0] opc_q, opc_d;
	logic msk_q, msk_d;
	logic [wsdf_pkg::LEN_W-1:0] len_q, len_d;
	logic [wsdf_pkg::LEN_W-1:0] rem_q, rem_d;
	logic [wsdf_pkg::MSG_W-1:0] mc_q, mc_d;

	logic [3:0] cnt_inc;
	logic [wsdf_pkg::LEN_W-1:0] rem_dec;
	logic [6:0] code;
	logic hdr_done, finish, emit, last, is_hdr, lom;

	always_comb begin
		phase_d  = phase_q;
		fbc_d    = fbc_q;
		fin_d    = fin_q;
		opc_d    = opc_q;
		msk_d    = msk_q;
		len_d    = len_q;
		rem_d    = rem_q;
		mc_d     = mc_q;
		hdr_done = 1'b0;
		finish   = 1'b0;
		emit     = 1'b0;
		last     = 1'b0;
		is_hdr   = 1'b0;
		code     = rx_byte[6:0];
		cnt_inc  = fbc_q + 4'd1;
		rem_dec  = (rem_q != '0) ? rem_q - 1'b1 : '0;

		case (phase_q)
			wsdf_pkg::PH_FIRST: begin
				fin_d   = rx_byte[7];
				opc_d   = rx_byte[3:0];
				phase_d = wsdf_pkg::PH_SECOND;
			end
			wsdf_pkg::PH_SECOND: begin
				msk_d = rx_byte[7];
				fbc_d = '0;
				len_d = '0;
				if (code == wsdf_pkg::LEN16_CODE) begin
					phase_d = wsdf_pkg::PH_EXT16;
				end else if (code == wsdf_pkg::LEN64_CODE) begin
					phase_d = wsdf_pkg::PH_EXT64;
				end else begin
					len_d    = wsdf_pkg::LEN_W'(code);
					hdr_done = 1'b1;
				end
			end
			wsdf_pkg::PH_EXT16, wsdf_pkg::PH_EXT64: begin
				len_d = {len_q[wsdf_pkg::LEN_W-9:0], rx_byte};
				fbc_d = cnt_inc;
				if (cnt_inc >= ((phase_q == wsdf_pkg::PH_EXT16) ?
					wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES)) begin
					hdr_done = 1'b1;
				end
			end
			wsdf_pkg::PH_KEY: begin
				fbc_d = cnt_inc;
				if (cnt_inc >= wsdf_pkg::KEY_BYTES) begin
					finish = 1'b1;
				end
			end
			wsdf_pkg::PH_PAYLOAD: begin
				if (mc_q != '1) begin
					mc_d = mc_q + 1'b1;
				end
				rem_d = rem_dec;
				last  = (rem_dec == '0);
				emit  = 1'b1;
				if (last) begin
					phase_d = wsdf_pkg::PH_FIRST;
				end
			end
			default: begin
				phase_d = wsdf_pkg::PH_FIRST;
			end
		endcase

		if (hdr_done) begin
			fbc_d = '0;
			if (msk_d) begin
				phase_d = wsdf_pkg::PH_KEY;
			end else begin
				finish = 1'b1;
			end
		end

		if (finish) begin
			rem_d   = len_d;
			fbc_d   = '0;
			emit    = 1'b1;
			is_hdr  = 1'b1;
			last    = (len_d == '0);
			phase_d = last ? wsdf_pkg::PH_FIRST : wsdf_pkg::PH_PAYLOAD;
		end

		lom = last & fin_d;

		rec.is_header       = is_hdr;
		rec.fin             = fin_d;
		rec.opcode          = opc_d;
		rec.masked          = msk_d;
		rec.payload_length  = wsdf_pkg::OUT_LEN_W'(len_d);
		rec.payload_byte    = is_hdr ? 8'd0 : rx_byte;
		rec.last_of_frame   = last;
		rec.last_of_message = lom;
		rec.message_length  = mc_d;

		if (emit && lom) begin
			mc_d = '0;
		end

		rec_valid = step & emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsdf_pkg::PH_FIRST;
			fbc_q   <= '0;
			fin_q   <= 1'b0;
			opc_q   <= '0;
			msk_q   <= 1'b0;
			len_q   <= '0;
			rem_q   <= '0;
			mc_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			fbc_q   <= fbc_d;
			fin_q   <= fin_d;
			opc_q   <= opc_d;
			msk_q   <= msk_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			mc_q    <= mc_d;
		end
	end

	`ASSERT_RST(a_fbc_bound, clk, arst_n, fbc_q <= wsdf_pkg::EXT64_BYTES)
	`ASSERT_RST(a_lom_clears, clk, arst_n, rec_valid && rec.last_of_message |=> mc_q == '0)
	`ASSERT_RST(a_last_to_first, clk, arst_n, rec_valid && rec.last_of_frame |=> phase_q == wsdf_pkg::PH_FIRST)
	`ASSERT_RST(a_hdr_rem, clk, arst_n, rec_valid && rec.is_header |=> rem_q == len_q)
	`ASSERT_RST(a_payload_rec, clk, arst_n, phase_q == wsdf_pkg::PH_PAYLOAD && step |-> rec_valid && !rec.is_header)

endmodule

>>> tb/websocket_frame_deframer_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer_top: drives frame byte streams,
// predicts header and payload records, and checks every output transfer.
// Depends on wsdf_pkg and websocket_frame_deframer_top.

module websocket_frame_deframer_top_test;
	import wsdf_pkg::*;

	localparam int RANDOM_BYTES = 1150;
	localparam int HOLD_CYCLES = 120;
	localparam int HOLD_AFTER = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam longint TIMEOUT_NS = 3_000_000;

	class deframe_tracker;
		phase_t phase;
		logic [3:0] field_cnt;
		logic frame_fin;
		logic [3:0] frame_op;
		logic frame_masked;
		logic [63:0] len_acc;
		logic [63:0] remaining;
		logic [63:0] msg_count;
		rec_t pending_records[$];
		int failures;
		int bytes_in;
		int headers_seen;
		int payload_seen;
		int messages_seen;

		function new();
			phase = PH_FIRST;
			field_cnt = '0;
			frame_fin = 1'b0;
			frame_op = '0;
			frame_masked = 1'b0;
			len_acc = '0;
			remaining = '0;
			msg_count = '0;
			failures = 0;
			bytes_in = 0;
			headers_seen = 0;
			payload_seen = 0;
			messages_seen = 0;
		endfunction

		function void push_record(logic hdr, logic [7:0] pbyte, logic last);
			rec_t r;
			r.is_header = hdr;
			r.fin = frame_fin;
			r.opcode = frame_op;
			r.masked = frame_masked;
			r.payload_length = len_acc;
			r.payload_byte = pbyte;
			r.last_of_frame = last;
			r.last_of_message = last & frame_fin;
			r.message_length = msg_count;
			if (r.last_of_message)
				msg_count = '0;
			pending_records.push_back(r);
		endfunction

		function void header_done();
			logic empty;
			empty = (len_acc == 0);
			remaining = len_acc;
			phase = empty ? PH_FIRST : PH_PAYLOAD;
			field_cnt = '0;
			push_record(1'b1, 8'h00, empty);
		endfunction

		function void length_done();
			logic [63:0] mask;
			mask = (LEN_W >= 64) ? {64{1'b1}} : ((64'd1 << LEN_W) - 64'd1);
			len_acc &= mask;
			field_cnt = '0;
			if (frame_masked)
				phase = PH_KEY;
			else
				header_done();
		endfunction

		function void take_byte(logic [7:0] b);
			logic last;
			bytes_in++;
			case (phase)
				PH_FIRST: begin
					frame_fin = b[7];
					frame_op = b[3:0];
					phase = PH_SECOND;
				end
				PH_SECOND: begin
					frame_masked = b[7];
					len_acc = '0;
					field_cnt = '0;
					if (b[6:0] == LEN16_CODE)
						phase = PH_EXT16;
					else if (b[6:0] == LEN64_CODE)
						phase = PH_EXT64;
					else begin
						len_acc = 64'(b[6:0]);
						length_done();
					end
				end
				PH_EXT16, PH_EXT64: begin
					len_acc = {len_acc[55:0], b};
					field_cnt = field_cnt + 4'd1;
					if (field_cnt >= ((phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES))
						length_done();
				end
				PH_KEY: begin
					field_cnt = field_cnt + 4'd1;
					if (field_cnt >= KEY_BYTES)
						header_done();
				end
				PH_PAYLOAD: begin
					if (msg_count != {64{1'b1}})
						msg_count++;
					if (remaining != 0)
						remaining--;
					last = (remaining == 0);
					if (last)
						phase = PH_FIRST;
					push_record(1'b0, b, last);
				end
				default: phase = PH_FIRST;
			endcase
		endfunction

		function void cmp_field(string name, logic [63:0] exp, logic [63:0] act);
			if (exp !== act) begin
				$error("%s: expected %0h, actual %0h", name, exp, act);
				failures++;
			end
		endfunction

		function void check_record(rec_t got);
			rec_t exp;
			if (pending_records.size() == 0) begin
				$error("output transfer with no record expected");
				failures++;
				return;
			end
			exp = pending_records.pop_front();
			cmp_field("is_header", 64'(exp.is_header), 64'(got.is_header));
			cmp_field("fin", 64'(exp.fin), 64'(got.fin));
			cmp_field("opcode", 64'(exp.opcode), 64'(got.opcode));
			cmp_field("masked", 64'(exp.masked), 64'(got.masked));
			cmp_field("payload_length", 64'(exp.payload_length),
				64'(got.payload_length));
			cmp_field("payload_byte", 64'(exp.payload_byte), 64'(got.payload_byte));
			cmp_field("last_of_frame", 64'(exp.last_of_frame), 64'(got.last_of_frame));
			cmp_field("last_of_message", 64'(exp.last_of_message),
				64'(got.last_of_message));
			cmp_field("message_length", 64'(exp.message_length),
				64'(got.message_length));
			if (exp.is_header)
				headers_seen++;
			else
				payload_seen++;
			if (exp.last_of_message)
				messages_seen++;
		endfunction

		function int pending();
			return pending_records.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic is_header;
	logic fin;
	logic [3:0] opcode;
	logic masked;
	logic [OUT_LEN_W-1:0] payload_length;
	logic [7:0] payload_byte;
	logic last_of_frame;
	logic last_of_message;
	logic [MSG_W-1:0] message_length;

	deframe_tracker tracker = new();
	int burst_left = 0;
	int bytes_sent = 0;
	int frame_idx = 0;
	bit hold_pending = 1'b1;

	websocket_frame_deframer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_header(is_header),
		.fin(fin),
		.opcode(opcode),
		.masked(masked),
		.payload_length(payload_length),
		.payload_byte(payload_byte),
		.last_of_frame(last_of_frame),
		.last_of_message(last_of_message),
		.message_length(message_length)
	);

	always #5 clk = ~clk;

	task automatic send_byte(logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		tracker.take_byte(b);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_random_frame();
		logic mask_bit;
		int unsigned kind;
		int unsigned len;
		mask_bit = 1'($urandom_range(0, 1));
		kind = $urandom_range(0, 9);
		send_byte({4'($urandom_range(0, 15)), 4'(frame_idx)});
		frame_idx++;
		if (kind < 8) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 6);
			send_byte({mask_bit, 7'(len)});
		end else begin
			len = ($urandom_range(0, 2) == 0) ? $urandom_range(126, 170) : $urandom_range(0, 20);
			if (kind == 8)
				send_byte({mask_bit, LEN16_CODE});
			else begin
				send_byte({mask_bit, LEN64_CODE});
				repeat (6) send_byte(8'h00);
			end
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end
		if (mask_bit)
			repeat (4) send_byte(8'($urandom_range(0, 255)));
		repeat (len) send_byte(8'($urandom_range(0, 255)));
	endtask

	// receiver: randomly chosen stall modes, plus one long hold-off
	initial begin
		int unsigned mode;
		int cyc;
		logic stall;
		mode = 0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_pending && tracker.bytes_in >= HOLD_AFTER) begin
				hold_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			cyc++;
			case (mode)
				0: stall = 1'b0;
				1: stall = ($urandom_range(0, 2) == 0);
				2: stall = ($urandom_range(0, 3) != 0);
				default: stall = (cyc % 3 == 0);
			endcase
			out_stall <= stall;
		end
	end

	always @(posedge clk) begin
		rec_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.is_header = is_header;
			got.fin = fin;
			got.opcode = opcode;
			got.masked = masked;
			got.payload_length = payload_length;
			got.payload_byte = payload_byte;
			got.last_of_frame = last_of_frame;
			got.last_of_message = last_of_message;
			got.message_length = message_length;
			tracker.check_record(got);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty final frame, then empty masked frame with opcode 15
		send_byte(8'h81);
		send_byte(8'h00);
		send_byte(8'h0F);
		send_byte(8'h80);
		repeat (4) send_byte(8'hA5);
		// 16-bit length below 126
		send_byte(8'h80);
		send_byte({1'b0, LEN16_CODE});
		send_byte(8'h00);
		send_byte(8'h02);
		send_byte(8'hAA);
		send_byte(8'h55);
		// 64-bit length below 126
		send_byte(8'h01);
		send_byte({1'b0, LEN64_CODE});
		repeat (7) send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'hFF);

		while (bytes_sent < 25 + RANDOM_BYTES)
			send_random_frame();

		// masked 64-bit length with every bit set; the frame never ends
		send_byte(8'h82);
		send_byte({1'b1, LEN64_CODE});
		repeat (8) send_byte(8'hFF);
		repeat (4) send_byte(8'($urandom_range(0, 255)));
		repeat (20) send_byte(8'($urandom_range(0, 255)));

		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d input bytes in %0d random frames plus directed cases,",
			tracker.bytes_in, frame_idx);
		$display("checking %0d headers, %0d payload bytes, %0d message ends, one long hold-off.",
			tracker.headers_seen, tracker.payload_seen, tracker.messages_seen);
		if (tracker.failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
